### hw/rtl/htc_pkg.sv
// Shared types, widths and helper functions for the humidity and temperature
// calibration block. No dependencies; every other file in hw/rtl uses it.
package htc_pkg;

    localparam int RAW_W     = 16;
    localparam int DIF_W     = RAW_W + 1;
    localparam int PT_W      = 7;
    localparam int DP_W      = PT_W + 1;
    localparam int BASE_W    = 12;
    localparam int PROD_W    = DIF_W + DP_W;
    localparam int NUM_W     = 28;
    localparam int QUO_W     = NUM_W - 1;
    localparam int DIV_W     = RAW_W;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_CELLS = QUO_W;
    localparam int HUM_CAL_W  = 8;
    localparam int TEMP_CAL_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HUM_CAL_LOW   = 3'd0,
        REG_HUM_CAL_HIGH  = 3'd1,
        REG_TEMP_CAL_LOW  = 3'd2,
        REG_TEMP_CAL_HIGH = 3'd3,
        REG_HUM_RAW_LOW   = 3'd4,
        REG_HUM_RAW_HIGH  = 3'd5,
        REG_TEMP_RAW_LOW  = 3'd6,
        REG_TEMP_RAW_HIGH = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [RAW_W-1:0] raw_humidity;
        logic signed [RAW_W-1:0] raw_temperature;
    } t_in_req;

    typedef struct packed {
        logic signed [RAW_W-1:0] humidity_tenths;
        logic signed [RAW_W-1:0] temperature_tenths;
        logic                    humidity_span_error;
        logic                    temperature_span_error;
    } t_out_req;

    typedef struct packed {
        logic [HUM_CAL_W-1:0]    hum_cal_low_x2;
        logic [HUM_CAL_W-1:0]    hum_cal_high_x2;
        logic [TEMP_CAL_W-1:0]   temp_cal_low_x8;
        logic [TEMP_CAL_W-1:0]   temp_cal_high_x8;
        logic signed [RAW_W-1:0] hum_raw_at_low;
        logic signed [RAW_W-1:0] hum_raw_at_high;
        logic signed [RAW_W-1:0] temp_raw_at_low;
        logic signed [RAW_W-1:0] temp_raw_at_high;
    } t_cal;

    // One channel as it moves through the divider cells
    typedef struct packed {
        logic [QUO_W-1:0]         quo;
        logic [DIV_W-1:0]         rem;
        logic [DIV_W-1:0]         dvs;
        logic                     neg;
        logic                     err;
        logic signed [BASE_W-1:0] base;
    } t_lane;

    typedef struct packed {
        t_lane hum;
        t_lane temp;
    } t_div_req;

    // Restoring division: one quotient bit per call
    function automatic t_lane div_step(t_lane l);
        logic [DIV_W:0] trial;
        logic           qbit;
        t_lane          r;
        r     = l;
        trial = {l.rem, l.quo[QUO_W-1]};
        if (trial >= {1'b0, l.dvs}) begin
            qbit  = 1'b1;
            trial = trial - {1'b0, l.dvs};
        end else begin
            qbit  = 1'b0;
        end
        r.rem = trial[DIV_W-1:0];
        r.quo = {l.quo[QUO_W-2:0], qbit};
        return r;
    endfunction

    // Scale by ten, take magnitudes and load the divider
    function automatic t_lane lane_load(logic signed [PROD_W-1:0] prod,
                                        logic signed [DIF_W-1:0] span,
                                        logic err,
                                        logic signed [BASE_W-1:0] base);
        logic signed [NUM_W-1:0] p;
        logic signed [NUM_W-1:0] num;
        logic signed [NUM_W-1:0] mag;
        logic signed [DIF_W-1:0] smag;
        t_lane                   r;
        p      = {{(NUM_W-PROD_W){prod[PROD_W-1]}}, prod};
        num    = (p <<< 3) + (p <<< 1);
        mag    = num[NUM_W-1] ? -num : num;
        smag   = span[DIF_W-1] ? -span : span;
        r.quo  = mag[QUO_W-1:0];
        r.rem  = '0;
        r.dvs  = smag[DIV_W-1:0];
        r.neg  = num[NUM_W-1] ^ span[DIF_W-1];
        r.err  = err;
        r.base = base;
        return r;
    endfunction

    // Apply sign, add the low point and saturate; a span error gives zero
    function automatic logic signed [RAW_W-1:0] lane_finish(t_lane l);
        logic signed [NUM_W:0] q;
        logic signed [NUM_W:0] v;
        logic signed [RAW_W-1:0] r;
        q = {2'b00, l.quo};
        if (l.neg) begin
            q = -q;
        end
        v = q + {{(NUM_W+1-BASE_W){l.base[BASE_W-1]}}, l.base};
        if (l.err) begin
            r = '0;
        end else if (v > (NUM_W+1)'(32767)) begin
            r = 16'sh7FFF;
        end else if (v < -(NUM_W+1)'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[RAW_W-1:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/htc_prep.sv
// Front end: raw offsets, point differences, product and divider load.
// Three registered stages with per-stage ready; uses htc_pkg.
module htc_prep (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  htc_pkg::t_cal     i_cal,
    input  logic              i_valid,
    output logic              o_ready,
    input  htc_pkg::t_in_req  i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output htc_pkg::t_div_req o_req
);

    typedef struct packed {
        logic signed [htc_pkg::DIF_W-1:0]  dif;
        logic signed [htc_pkg::DP_W-1:0]   dp;
        logic signed [htc_pkg::DIF_W-1:0]  span;
        logic signed [htc_pkg::BASE_W-1:0] base;
        logic                              err;
    } t_front;

    typedef struct packed {
        logic signed [htc_pkg::PROD_W-1:0] prod;
        logic signed [htc_pkg::DIF_W-1:0]  span;
        logic signed [htc_pkg::BASE_W-1:0] base;
        logic                              err;
    } t_mid;

    function automatic t_front front(logic signed [htc_pkg::RAW_W-1:0] raw,
                                     logic signed [htc_pkg::RAW_W-1:0] raw_lo,
                                     logic signed [htc_pkg::RAW_W-1:0] raw_hi,
                                     logic [htc_pkg::PT_W-1:0] p_lo,
                                     logic [htc_pkg::PT_W-1:0] p_hi);
        t_front r;
        r.dif  = {raw[htc_pkg::RAW_W-1], raw} - {raw_lo[htc_pkg::RAW_W-1], raw_lo};
        r.span = {raw_hi[htc_pkg::RAW_W-1], raw_hi} - {raw_lo[htc_pkg::RAW_W-1], raw_lo};
        r.dp   = {1'b0, p_hi} - {1'b0, p_lo};
        r.base = ({2'b00, p_lo, 3'b000}) + ({4'b0000, p_lo, 1'b0});
        r.err  = (raw_hi == raw_lo);
        return r;
    endfunction

    function automatic t_mid mid(t_front f);
        t_mid r;
        r.prod = f.dif * f.dp;
        r.span = f.span;
        r.base = f.base;
        r.err  = f.err;
        return r;
    endfunction

    logic   r_v1, r_v2, r_v3;
    t_front r_h1, r_t1;
    t_mid   r_h2, r_t2;
    htc_pkg::t_div_req r_req3;
    logic   rdy1, rdy2, rdy3;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_req   = r_req3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_h1 <= front(i_req.raw_humidity, i_cal.hum_raw_at_low, i_cal.hum_raw_at_high,
                          i_cal.hum_cal_low_x2[htc_pkg::HUM_CAL_W-1:1],
                          i_cal.hum_cal_high_x2[htc_pkg::HUM_CAL_W-1:1]);
            r_t1 <= front(i_req.raw_temperature, i_cal.temp_raw_at_low,
                          i_cal.temp_raw_at_high,
                          i_cal.temp_cal_low_x8[htc_pkg::TEMP_CAL_W-1:3],
                          i_cal.temp_cal_high_x8[htc_pkg::TEMP_CAL_W-1:3]);
        end
        if (rdy2 && r_v1) begin
            r_h2 <= mid(r_h1);
            r_t2 <= mid(r_t1);
        end
        if (rdy3 && r_v2) begin
            r_req3.hum  <= htc_pkg::lane_load(r_h2.prod, r_h2.span, r_h2.err, r_h2.base);
            r_req3.temp <= htc_pkg::lane_load(r_t2.prod, r_t2.span, r_t2.err, r_t2.base);
        end
    end

endmodule

### hw/rtl/htc_div_cell.sv
// One divider cell: resolves one quotient bit for both channels.
// Holds its request until the next cell takes it; uses htc_pkg.
module htc_div_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  htc_pkg::t_div_req i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output htc_pkg::t_div_req o_req
);

    logic              r_valid;
    htc_pkg::t_div_req r_req;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req.hum  <= htc_pkg::div_step(i_req.hum);
            r_req.temp <= htc_pkg::div_step(i_req.temp);
        end
    end

endmodule

### hw/rtl/htc_post.sv
// Output stage: sign, low point offset, saturation and the result register.
// Uses htc_pkg.
module htc_post (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  htc_pkg::t_div_req i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output htc_pkg::t_out_req o_req
);

    logic              r_valid;
    htc_pkg::t_out_req r_req;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req.humidity_tenths        <= htc_pkg::lane_finish(i_req.hum);
            r_req.temperature_tenths     <= htc_pkg::lane_finish(i_req.temp);
            r_req.humidity_span_error    <= i_req.hum.err;
            r_req.temperature_span_error <= i_req.temp.err;
        end
    end

endmodule

### hw/rtl/humidity_temp_calibration.sv
// Top level of the humidity and temperature calibration block: registers,
// front end, divider cell chain and output stage. Uses htc_pkg and all htc_ modules.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------
//  input    | i_valid / o_ready  | i_req  (htc_pkg::t_in_req)
//  output   | o_valid / i_ready  | o_req  (htc_pkg::t_out_req)
//  config   | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One request per cycle sustained while the output is taken; three front-end stages,
// one divider cell per quotient bit (27) and the output register.
// Every stage has its own ready, so bubbles close up under an output stall.
// Synchronous active-low reset clears valid bits and calibration registers.
module humidity_temp_calibration (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  htc_pkg::t_in_req               i_req,
    output logic                           o_valid,
    input  logic                           i_ready,
    output htc_pkg::t_out_req              o_req,
    input  logic                           i_cfg_we,
    input  logic [htc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [htc_pkg::CFG_W-1:0]      i_cfg_data
);

    htc_pkg::t_cal     r_cal;
    htc_pkg::t_reg_idx cfg_idx;

    logic              cell_valid [htc_pkg::NUM_CELLS+1];
    logic              cell_ready [htc_pkg::NUM_CELLS+1];
    htc_pkg::t_div_req cell_req   [htc_pkg::NUM_CELLS+1];

    assign cfg_idx = htc_pkg::t_reg_idx'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            case (cfg_idx)
                htc_pkg::REG_HUM_CAL_LOW: begin
                    r_cal.hum_cal_low_x2 <= i_cfg_data[htc_pkg::HUM_CAL_W-1:0];
                end
                htc_pkg::REG_HUM_CAL_HIGH: begin
                    r_cal.hum_cal_high_x2 <= i_cfg_data[htc_pkg::HUM_CAL_W-1:0];
                end
                htc_pkg::REG_TEMP_CAL_LOW: begin
                    r_cal.temp_cal_low_x8 <= i_cfg_data[htc_pkg::TEMP_CAL_W-1:0];
                end
                htc_pkg::REG_TEMP_CAL_HIGH: begin
                    r_cal.temp_cal_high_x8 <= i_cfg_data[htc_pkg::TEMP_CAL_W-1:0];
                end
                htc_pkg::REG_HUM_RAW_LOW: begin
                    r_cal.hum_raw_at_low <= i_cfg_data[htc_pkg::RAW_W-1:0];
                end
                htc_pkg::REG_HUM_RAW_HIGH: begin
                    r_cal.hum_raw_at_high <= i_cfg_data[htc_pkg::RAW_W-1:0];
                end
                htc_pkg::REG_TEMP_RAW_LOW: begin
                    r_cal.temp_raw_at_low <= i_cfg_data[htc_pkg::RAW_W-1:0];
                end
                htc_pkg::REG_TEMP_RAW_HIGH: begin
                    r_cal.temp_raw_at_high <= i_cfg_data[htc_pkg::RAW_W-1:0];
                end
                default: begin
                    r_cal <= r_cal;
                end
            endcase
        end
    end

    htc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (r_cal),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (cell_valid[0]),
        .i_ready (cell_ready[0]),
        .o_req   (cell_req[0])
    );

    for (genvar g = 0; g < htc_pkg::NUM_CELLS; g++) begin : g_cell
        htc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cell_valid[g]),
            .o_ready (cell_ready[g]),
            .i_req   (cell_req[g]),
            .o_valid (cell_valid[g+1]),
            .i_ready (cell_ready[g+1]),
            .o_req   (cell_req[g+1])
        );
    end

    htc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cell_valid[htc_pkg::NUM_CELLS]),
        .o_ready (cell_ready[htc_pkg::NUM_CELLS]),
        .i_req   (cell_req[htc_pkg::NUM_CELLS]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_req   (o_req)
    );

endmodule

### dv/tb_top.sv
// Self-checking testbench for humidity_temp_calibration: drives sample-pair
// requests, predicts the interpolated tenths and span flags, checks each result.
// Depends on htc_pkg and the humidity_temp_calibration RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 40;

    typedef enum logic {RX_ALWAYS, RX_PATTERN} t_rx_mode;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    htc_pkg::t_in_req              i_req;
    logic                          o_valid;
    logic                          i_ready;
    htc_pkg::t_out_req             o_req;
    logic                          i_cfg_we;
    logic [htc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [htc_pkg::CFG_W-1:0]     i_cfg_data;

    htc_pkg::t_cal     cal_shadow;
    htc_pkg::t_out_req tenths_due[$];
    htc_pkg::t_out_req tenths_head;
    t_rx_mode rx_mode = RX_ALWAYS;
    bit       tx_bursty = 1'b1;
    bit       rx_level = 1'b1;
    int       burst_left = 0;
    int       hold_asks = 0;
    int       hold_seen = 0;
    int       hold_left = 0;
    int       rx_run = 0;
    int       mismatches = 0;
    int       samples_sent = 0;
    int       results_seen = 0;
    int       cal_writes = 0;

    humidity_temp_calibration dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_req       (o_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic logic signed [htc_pkg::RAW_W-1:0] interp_tenths(
        int raw, int pt_lo_scaled, int pt_hi_scaled, int divisor,
        int raw_lo, int raw_hi, output logic span_err);
        longint p_lo;
        longint p_hi;
        longint span;
        longint num;
        longint v;
        p_lo = pt_lo_scaled / divisor;
        p_hi = pt_hi_scaled / divisor;
        span = longint'(raw_hi) - longint'(raw_lo);
        if (span == 0) begin
            span_err = 1'b1;
            return '0;
        end
        span_err = 1'b0;
        num = (longint'(raw) - longint'(raw_lo)) * (p_hi - p_lo) * 10;
        v = num / span + p_lo * 10;
        if (v > 32767) begin
            v = 32767;
        end else if (v < -32768) begin
            v = -32768;
        end
        return v[htc_pkg::RAW_W-1:0];
    endfunction

    function automatic htc_pkg::t_out_req predict_tenths(htc_pkg::t_in_req s);
        htc_pkg::t_out_req r;
        logic              herr;
        logic              terr;
        r.humidity_tenths = interp_tenths(int'($signed(s.raw_humidity)),
                                          int'(cal_shadow.hum_cal_low_x2),
                                          int'(cal_shadow.hum_cal_high_x2), 2,
                                          int'($signed(cal_shadow.hum_raw_at_low)),
                                          int'($signed(cal_shadow.hum_raw_at_high)), herr);
        r.temperature_tenths = interp_tenths(int'($signed(s.raw_temperature)),
                                             int'(cal_shadow.temp_cal_low_x8),
                                             int'(cal_shadow.temp_cal_high_x8), 8,
                                             int'($signed(cal_shadow.temp_raw_at_low)),
                                             int'($signed(cal_shadow.temp_raw_at_high)), terr);
        r.humidity_span_error    = herr;
        r.temperature_span_error = terr;
        return r;
    endfunction

    function automatic void random_raw_pair(output int lo, output int hi);
        int extremes[5];
        int style;
        extremes = '{-32768, -1, 0, 1, 32767};
        style = $urandom_range(0, 3);
        case (style)
            0: begin
                lo = int'($signed(16'($urandom)));
                hi = int'($signed(16'($urandom)));
            end
            1: begin
                lo = int'($signed(16'($urandom)));
                hi = lo + int'($urandom_range(0, 6)) - 3;
                if (hi > 32767) hi = 32767;
                if (hi < -32768) hi = -32768;
            end
            2: begin
                lo = -int'($urandom_range(0, 20000));
                hi = int'($urandom_range(1, 20000));
                if ($urandom_range(0, 1) == 1) begin
                    lo = -lo;
                    hi = -hi;
                end
            end
            default: begin
                lo = extremes[$urandom_range(0, 4)];
                hi = extremes[$urandom_range(0, 4)];
            end
        endcase
    endfunction

    function automatic htc_pkg::t_cal random_cal();
        htc_pkg::t_cal c;
        int            lo;
        int            hi;
        c.hum_cal_low_x2   = 8'($urandom);
        c.hum_cal_high_x2  = 8'($urandom);
        c.temp_cal_low_x8  = 10'($urandom);
        c.temp_cal_high_x8 = 10'($urandom);
        random_raw_pair(lo, hi);
        c.hum_raw_at_low  = 16'(lo);
        c.hum_raw_at_high = 16'(hi);
        random_raw_pair(lo, hi);
        c.temp_raw_at_low  = 16'(lo);
        c.temp_raw_at_high = 16'(hi);
        return c;
    endfunction

    // Mostly near the calibrated raw range, sometimes anywhere
    function automatic int pick_raw(logic signed [htc_pkg::RAW_W-1:0] a,
                                    logic signed [htc_pkg::RAW_W-1:0] b);
        int lo;
        int hi;
        if ($urandom_range(0, 9) < 3) begin
            return int'($signed(16'($urandom)));
        end
        lo = (a < b) ? int'(a) : int'(b);
        hi = (a < b) ? int'(b) : int'(a);
        lo = (lo - 200 < -32768) ? -32768 : lo - 200;
        hi = (hi + 200 > 32767) ? 32767 : hi + 200;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task automatic write_cal_reg(htc_pkg::t_reg_idx idx, logic [htc_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            htc_pkg::REG_HUM_CAL_LOW: begin
                cal_shadow.hum_cal_low_x2 = data[htc_pkg::HUM_CAL_W-1:0];
            end
            htc_pkg::REG_HUM_CAL_HIGH: begin
                cal_shadow.hum_cal_high_x2 = data[htc_pkg::HUM_CAL_W-1:0];
            end
            htc_pkg::REG_TEMP_CAL_LOW: begin
                cal_shadow.temp_cal_low_x8 = data[htc_pkg::TEMP_CAL_W-1:0];
            end
            htc_pkg::REG_TEMP_CAL_HIGH: begin
                cal_shadow.temp_cal_high_x8 = data[htc_pkg::TEMP_CAL_W-1:0];
            end
            htc_pkg::REG_HUM_RAW_LOW:  cal_shadow.hum_raw_at_low  = data;
            htc_pkg::REG_HUM_RAW_HIGH: cal_shadow.hum_raw_at_high = data;
            htc_pkg::REG_TEMP_RAW_LOW: cal_shadow.temp_raw_at_low = data;
            default:                   cal_shadow.temp_raw_at_high = data;
        endcase
        cal_writes++;
    endtask

    // Fill unused upper bits with noise; the block must drop them
    task automatic load_cal(htc_pkg::t_cal c);
        write_cal_reg(htc_pkg::REG_HUM_CAL_LOW,   {8'($urandom), c.hum_cal_low_x2});
        write_cal_reg(htc_pkg::REG_HUM_CAL_HIGH,  {8'($urandom), c.hum_cal_high_x2});
        write_cal_reg(htc_pkg::REG_TEMP_CAL_LOW,  {6'($urandom), c.temp_cal_low_x8});
        write_cal_reg(htc_pkg::REG_TEMP_CAL_HIGH, {6'($urandom), c.temp_cal_high_x8});
        write_cal_reg(htc_pkg::REG_HUM_RAW_LOW,   c.hum_raw_at_low);
        write_cal_reg(htc_pkg::REG_HUM_RAW_HIGH,  c.hum_raw_at_high);
        write_cal_reg(htc_pkg::REG_TEMP_RAW_LOW,  c.temp_raw_at_low);
        write_cal_reg(htc_pkg::REG_TEMP_RAW_HIGH, c.temp_raw_at_high);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tenths_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic pace_sender();
        int gap;
        if (!tx_bursty) return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            i_valid <= 1'b0;
            i_req   <= htc_pkg::t_in_req'($urandom);
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    task automatic send_sample(int hum, int temp);
        htc_pkg::t_in_req s;
        s.raw_humidity    = 16'(hum);
        s.raw_temperature = 16'(temp);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_req   <= s;
        do @(posedge i_clk); while (!o_ready);
        tenths_due.push_back(predict_tenths(s));
        samples_sent++;
        pace_sender();
    endtask

    task automatic send_random_samples(int count);
        repeat (count) begin
            send_sample(pick_raw(cal_shadow.hum_raw_at_low, cal_shadow.hum_raw_at_high),
                        pick_raw(cal_shadow.temp_raw_at_low, cal_shadow.temp_raw_at_high));
        end
    endtask

    // All registers zero after reset: both spans are zero
    task automatic test_reset_state();
        send_sample(0, 0);
        send_sample(32767, -32768);
        send_sample(-32768, 32767);
    endtask

    task automatic test_directed_cal();
        wait_idle();
        load_cal('{hum_cal_low_x2: 8'h40, hum_cal_high_x2: 8'hC8,
                   temp_cal_low_x8: 10'h0F0, temp_cal_high_x8: 10'h3FF,
                   hum_raw_at_low: 16'sh8000, hum_raw_at_high: 16'sh7FFF,
                   temp_raw_at_low: 16'sh7FFF, temp_raw_at_high: 16'sh8000});
        send_sample(-32768, 32767);
        send_sample(32767, -32768);
        send_sample(0, 0);
        send_sample(-1, 1);
        send_sample(12345, -12345);
        // Unit span saturates humidity; temperature span is zero
        wait_idle();
        load_cal('{hum_cal_low_x2: 8'd0, hum_cal_high_x2: 8'd255,
                   temp_cal_low_x8: 10'd1023, temp_cal_high_x8: 10'd0,
                   hum_raw_at_low: 16'sd0, hum_raw_at_high: 16'sd1,
                   temp_raw_at_low: 16'sd100, temp_raw_at_high: 16'sd100});
        send_sample(32767, 5);
        send_sample(-32768, -5);
        send_sample(0, 100);
        send_sample(1, 0);
        send_sample(-1, 32767);
        // Odd points truncate; falling slopes and negative numerators
        wait_idle();
        load_cal('{hum_cal_low_x2: 8'd255, hum_cal_high_x2: 8'd1,
                   temp_cal_low_x8: 10'd1023, temp_cal_high_x8: 10'd7,
                   hum_raw_at_low: -16'sd100, hum_raw_at_high: 16'sd200,
                   temp_raw_at_low: -16'sd5, temp_raw_at_high: -16'sd2});
        send_sample(-100, -5);
        send_sample(200, -2);
        send_sample(50, -3);
        send_sample(-32768, 32767);
        send_sample(7, -4);
        // Maximum points, zero slope
        wait_idle();
        load_cal('{hum_cal_low_x2: 8'd255, hum_cal_high_x2: 8'd255,
                   temp_cal_low_x8: 10'd1023, temp_cal_high_x8: 10'd1023,
                   hum_raw_at_low: 16'sh8000, hum_raw_at_high: 16'sh8001,
                   temp_raw_at_low: 16'sh7FFE, temp_raw_at_high: 16'sh7FFF});
        send_sample(1, 1);
        send_sample(-32768, 32767);
        send_sample(32767, -32768);
    endtask

    task automatic test_random_cal(int phases, int per_phase);
        repeat (phases) begin
            wait_idle();
            load_cal(random_cal());
            rx_mode   = ($urandom_range(0, 3) == 0) ? RX_ALWAYS : RX_PATTERN;
            tx_bursty = ($urandom_range(0, 3) != 0);
            send_random_samples(per_phase);
        end
        tx_bursty = 1'b1;
    endtask

    // Hold the output long enough for the pipeline to fill and stall the input
    task automatic test_backpressure();
        wait_idle();
        load_cal(random_cal());
        rx_mode   = RX_PATTERN;
        tx_bursty = 1'b0;
        hold_asks++;
        send_random_samples(150);
        tx_bursty = 1'b1;
    endtask

    task automatic test_full_rate();
        wait_idle();
        load_cal(random_cal());
        rx_mode   = RX_ALWAYS;
        tx_bursty = 1'b0;
        send_random_samples(100);
        tx_bursty = 1'b1;
        rx_mode   = RX_PATTERN;
    endtask

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (rx_mode == RX_ALWAYS) begin
                i_ready <= 1'b1;
            end else begin
                if (rx_run == 0) begin
                    rx_level = !rx_level;
                    rx_run = rx_level ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                rx_run--;
                i_ready <= rx_level;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (tenths_due.size() == 0) begin
                mismatches++;
                $display("%0t ns: result with none expected: expected none actual %h",
                         $time, o_req);
            end else begin
                tenths_head = tenths_due.pop_front();
                results_seen++;
                if (o_req.humidity_tenths !== tenths_head.humidity_tenths) begin
                    mismatches++;
                    $display("%0t ns: humidity_tenths expected %0d actual %0d", $time,
                             $signed(tenths_head.humidity_tenths),
                             $signed(o_req.humidity_tenths));
                end
                if (o_req.temperature_tenths !== tenths_head.temperature_tenths) begin
                    mismatches++;
                    $display("%0t ns: temperature_tenths expected %0d actual %0d", $time,
                             $signed(tenths_head.temperature_tenths),
                             $signed(o_req.temperature_tenths));
                end
                if (o_req.humidity_span_error !== tenths_head.humidity_span_error) begin
                    mismatches++;
                    $display("%0t ns: humidity_span_error expected %0b actual %0b", $time,
                             tenths_head.humidity_span_error, o_req.humidity_span_error);
                end
                if (o_req.temperature_span_error !== tenths_head.temperature_span_error) begin
                    mismatches++;
                    $display("%0t ns: temperature_span_error expected %0b actual %0b", $time,
                             tenths_head.temperature_span_error,
                             o_req.temperature_span_error);
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        cal_shadow  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        rx_mode = RX_PATTERN;
        test_reset_state();
        test_directed_cal();
        test_random_cal(6, 150);
        test_backpressure();
        test_full_rate();
        wait_idle();

        $display("Run: %0d sample requests, %0d results checked, %0d register writes",
                 samples_sent, results_seen, cal_writes);
        $display("Run: reset state, zero spans, saturation, masked bits, random calibrations,"
                 , " output hold-off and full-rate streaming");
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/htc_pkg.sv
hw/rtl/htc_prep.sv
hw/rtl/htc_div_cell.sv
hw/rtl/htc_post.sv
hw/rtl/humidity_temp_calibration.sv
dv/tb_top.sv
